[rtl/dhcpx_pkg.sv]
// Shared types, codes and helper functions for the DHCP option extractor.
package dhcpx_pkg;

	typedef enum logic [2:0] {
		PH_MAGIC = 3'd0,
		PH_CODE  = 3'd1,
		PH_LEN   = 3'd2,
		PH_VALUE = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ST_END       = 2'd0,
		ST_BAD_MAGIC = 2'd1,
		ST_TRUNC     = 2'd2
	} status_t;

	localparam logic [7:0] OPT_PAD     = 8'd0;
	localparam logic [7:0] OPT_MASK    = 8'd1;
	localparam logic [7:0] OPT_GATEWAY = 8'd3;
	localparam logic [7:0] OPT_DNS     = 8'd6;
	localparam logic [7:0] OPT_END     = 8'd255;

	localparam logic [1:0] MAGIC_LAST   = 2'd3;
	localparam logic [2:0] VALUE_LANES  = 3'd4;

	localparam int FOUND_MASK    = 0;
	localparam int FOUND_GATEWAY = 1;
	localparam int FOUND_DNS     = 2;

	typedef struct packed {
		status_t     status;
		logic [31:0] subnet_mask;
		logic [31:0] gateway_addr;
		logic [31:0] dns_addr;
		logic [2:0]  found;
	} result_t;

	function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'd99;
			2'd1: b = 8'd130;
			2'd2: b = 8'd83;
			2'd3: b = 8'd99;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	function automatic logic [31:0] put_lane(input logic [31:0] hold, input logic [1:0] idx,
			input logic [7:0] b);
		logic [31:0] r;
		r = hold;
		unique case (idx)
			2'd0: r[31:24] = b;
			2'd1: r[23:16] = b;
			2'd2: r[15:8]  = b;
			2'd3: r[7:0]   = b;
			default: r = hold;
		endcase
		return r;
	endfunction

endpackage

[rtl/dhcpx_parser.sv]
// Parser state registers and the combinational next-state logic for one options byte.
module dhcpx_parser
	import dhcpx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       field_start,
	input  logic       field_last,
	output logic       have,
	output result_t    res
);

	phase_t      phase_q, ph_d;
	logic [1:0]  magic_index_q, mi_d;
	logic        magic_bad_q, mb_d;
	logic [7:0]  current_code_q, cc_d;
	logic [7:0]  bytes_left_q, bl_d;
	logic [2:0]  value_index_q, vi_d;
	logic [31:0] mask_hold_q, mask_d;
	logic [31:0] gateway_hold_q, gw_d;
	logic [31:0] dns_hold_q, dns_d;
	logic [2:0]  found_q, ff_d;
	status_t     status_d;

	always_comb begin
		ph_d     = field_start ? PH_MAGIC : phase_q;
		mi_d     = field_start ? 2'd0 : magic_index_q;
		mb_d     = field_start ? 1'b0 : magic_bad_q;
		cc_d     = field_start ? 8'd0 : current_code_q;
		bl_d     = field_start ? 8'd0 : bytes_left_q;
		vi_d     = field_start ? 3'd0 : value_index_q;
		ff_d     = field_start ? 3'd0 : found_q;
		mask_d   = mask_hold_q;
		gw_d     = gateway_hold_q;
		dns_d    = dns_hold_q;
		have     = 1'b0;
		status_d = ST_END;

		unique case (ph_d)
			PH_MAGIC: begin
				if (data_byte != cookie_byte(mi_d))
					mb_d = 1'b1;
				if (mi_d == MAGIC_LAST) begin
					mi_d = 2'd0;
					if (mb_d) begin
						ph_d     = PH_DONE;
						have     = 1'b1;
						status_d = ST_BAD_MAGIC;
					end else begin
						ph_d = PH_CODE;
					end
				end else begin
					mi_d = mi_d + 2'd1;
				end
			end
			PH_CODE: begin
				if (data_byte == OPT_END) begin
					ph_d     = PH_DONE;
					have     = 1'b1;
					status_d = ST_END;
				end else if (data_byte != OPT_PAD) begin
					cc_d = data_byte;
					ph_d = PH_LEN;
				end
			end
			PH_LEN: begin
				if (cc_d == OPT_MASK)
					ff_d[FOUND_MASK] = 1'b1;
				else if (cc_d == OPT_GATEWAY)
					ff_d[FOUND_GATEWAY] = 1'b1;
				else if (cc_d == OPT_DNS)
					ff_d[FOUND_DNS] = 1'b1;
				bl_d = data_byte;
				vi_d = 3'd0;
				ph_d = (data_byte == 8'd0) ? PH_CODE : PH_VALUE;
			end
			PH_VALUE: begin
				if (vi_d < VALUE_LANES) begin
					if (cc_d == OPT_MASK)
						mask_d = put_lane(mask_d, vi_d[1:0], data_byte);
					else if (cc_d == OPT_GATEWAY)
						gw_d = put_lane(gw_d, vi_d[1:0], data_byte);
					else if (cc_d == OPT_DNS)
						dns_d = put_lane(dns_d, vi_d[1:0], data_byte);
					vi_d = vi_d + 3'd1;
				end
				bl_d = bl_d - 8'd1;
				if (bl_d == 8'd0)
					ph_d = PH_CODE;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (field_last && !have && ph_d != PH_DONE) begin
			ph_d     = PH_DONE;
			have     = 1'b1;
			status_d = ST_TRUNC;
		end

		res.status       = status_d;
		res.subnet_mask  = mask_d;
		res.gateway_addr = gw_d;
		res.dns_addr     = dns_d;
		res.found        = ff_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_MAGIC;
			magic_index_q  <= 2'd0;
			magic_bad_q    <= 1'b0;
			current_code_q <= 8'd0;
			bytes_left_q   <= 8'd0;
			value_index_q  <= 3'd0;
			mask_hold_q    <= 32'd0;
			gateway_hold_q <= 32'd0;
			dns_hold_q     <= 32'd0;
			found_q        <= 3'd0;
		end else if (accept) begin
			phase_q        <= ph_d;
			magic_index_q  <= mi_d;
			magic_bad_q    <= mb_d;
			current_code_q <= cc_d;
			bytes_left_q   <= bl_d;
			value_index_q  <= vi_d;
			mask_hold_q    <= mask_d;
			gateway_hold_q <= gw_d;
			dns_hold_q     <= dns_d;
			found_q        <= ff_d;
		end
	end

endmodule

[rtl/dhcpx_out_reg.sv]
// Result register that holds one result request until the downstream side takes it.
module dhcpx_out_reg
	import dhcpx_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    out_ready,
	output logic    out_valid,
	output logic    room,
	output result_t res_q
);

	logic valid_q;

	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule

[rtl/dhcp_option_extract.sv]
// Top level of the DHCP option extractor: byte parser followed by a result register.
// A result appears on out_valid in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle, set by the single parser state update per byte.
// A waiting result stalls input only while out_ready is low.
// Reset (arst_n low) returns the parser to the magic phase and clears held values and flags.
module dhcp_option_extract
	import dhcpx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        field_start,
	input  logic        field_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] subnet_mask,
	output logic [31:0] gateway_addr,
	output logic [31:0] dns_addr,
	output logic        mask_found,
	output logic        gateway_found,
	output logic        dns_found
);

	logic    accept;
	logic    have;
	logic    room;
	result_t res;
	result_t res_q;

	assign in_ready = room;
	assign accept   = in_valid && room;

	dhcpx_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.data_byte   (data_byte),
		.field_start (field_start),
		.field_last  (field_last),
		.have        (have),
		.res         (res)
	);

	dhcpx_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && have),
		.res       (res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.room      (room),
		.res_q     (res_q)
	);

	assign status        = res_q.status;
	assign subnet_mask   = res_q.subnet_mask;
	assign gateway_addr  = res_q.gateway_addr;
	assign dns_addr      = res_q.dns_addr;
	assign mask_found    = res_q.found[FOUND_MASK];
	assign gateway_found = res_q.found[FOUND_GATEWAY];
	assign dns_found     = res_q.found[FOUND_DNS];

	// A waiting result must hold off new bytes until it is taken.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the result register occupancy");

	// A one-byte field can never complete the cookie, so it is always truncated.
	a_single_byte_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && field_start && field_last)
		|=> (out_valid && status == ST_TRUNC))
		else $error("one-byte field did not give a truncated result");

	// A bad cookie is found before any option record, so no found flag can be set.
	a_bad_magic_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BAD_MAGIC)
		|-> (!mask_found && !gateway_found && !dns_found))
		else $error("found flag set on a bad cookie result");

endmodule

[dv/dhcp_option_extract_checker.sv]
`timescale 1ns / 100ps
// Checker for the DHCP option extractor: predicts results from accepted requests and compares them.
module dhcp_option_extract_checker
	import dhcpx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        field_start,
	input  logic        field_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [31:0] subnet_mask,
	input  logic [31:0] gateway_addr,
	input  logic [31:0] dns_addr,
	input  logic        mask_found,
	input  logic        gateway_found,
	input  logic        dns_found,
	output int          fail_count,
	output int          outstanding
);

	localparam logic [31:0] COOKIE = {8'd99, 8'd130, 8'd83, 8'd99};

	phase_t      parse_at;
	logic [1:0]  cookie_pos;
	logic        cookie_err;
	logic [7:0]  rec_code;
	logic [7:0]  rec_left;
	logic [2:0]  lane_cnt;
	logic [31:0] mask_val;
	logic [31:0] gw_val;
	logic [31:0] dns_val;
	logic [2:0]  seen;
	result_t     result_q[$];
	int          mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %h, got %h", $realtime, what, want, got);
	endtask

	task automatic restart_field();
		parse_at   = PH_MAGIC;
		cookie_pos = '0;
		cookie_err = 1'b0;
		rec_code   = '0;
		rec_left   = '0;
		lane_cnt   = '0;
		seen       = '0;
	endtask

	task automatic predict_request(input logic [7:0] b, input logic opens, input logic closes);
		result_t r;
		logic    fire;
		status_t code;
		fire = 1'b0;
		code = ST_END;
		if (opens)
			restart_field();
		case (parse_at)
			PH_MAGIC: begin
				if (b != COOKIE[31 - 8 * int'(cookie_pos) -: 8])
					cookie_err = 1'b1;
				if (cookie_pos == 2'd3) begin
					cookie_pos = '0;
					if (cookie_err) begin
						parse_at = PH_DONE;
						fire     = 1'b1;
						code     = ST_BAD_MAGIC;
					end else begin
						parse_at = PH_CODE;
					end
				end else begin
					cookie_pos = cookie_pos + 2'd1;
				end
			end
			PH_CODE: begin
				if (b == OPT_END) begin
					parse_at = PH_DONE;
					fire     = 1'b1;
					code     = ST_END;
				end else if (b != OPT_PAD) begin
					rec_code = b;
					parse_at = PH_LEN;
				end
			end
			PH_LEN: begin
				if (rec_code == OPT_MASK)
					seen[FOUND_MASK] = 1'b1;
				else if (rec_code == OPT_GATEWAY)
					seen[FOUND_GATEWAY] = 1'b1;
				else if (rec_code == OPT_DNS)
					seen[FOUND_DNS] = 1'b1;
				rec_left = b;
				lane_cnt = '0;
				parse_at = (b == 8'd0) ? PH_CODE : PH_VALUE;
			end
			PH_VALUE: begin
				if (lane_cnt < VALUE_LANES) begin
					if (rec_code == OPT_MASK)
						mask_val[31 - 8 * int'(lane_cnt) -: 8] = b;
					else if (rec_code == OPT_GATEWAY)
						gw_val[31 - 8 * int'(lane_cnt) -: 8] = b;
					else if (rec_code == OPT_DNS)
						dns_val[31 - 8 * int'(lane_cnt) -: 8] = b;
					lane_cnt = lane_cnt + 3'd1;
				end
				rec_left = rec_left - 8'd1;
				if (rec_left == 8'd0)
					parse_at = PH_CODE;
			end
			default: ;
		endcase
		if (closes && !fire && parse_at != PH_DONE) begin
			parse_at = PH_DONE;
			fire     = 1'b1;
			code     = ST_TRUNC;
		end
		if (fire) begin
			r.status       = code;
			r.subnet_mask  = mask_val;
			r.gateway_addr = gw_val;
			r.dns_addr     = dns_val;
			r.found        = seen;
			result_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			restart_field();
			mask_val = '0;
			gw_val   = '0;
			dns_val  = '0;
			result_q.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("unexpected result, status", '0, 32'(status));
				end else begin
					want = result_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(status));
					if (subnet_mask !== want.subnet_mask)
						report_mismatch("subnet_mask", want.subnet_mask, subnet_mask);
					if (gateway_addr !== want.gateway_addr)
						report_mismatch("gateway_addr", want.gateway_addr, gateway_addr);
					if (dns_addr !== want.dns_addr)
						report_mismatch("dns_addr", want.dns_addr, dns_addr);
					if (mask_found !== want.found[FOUND_MASK])
						report_mismatch("mask_found", 32'(want.found[FOUND_MASK]),
							32'(mask_found));
					if (gateway_found !== want.found[FOUND_GATEWAY])
						report_mismatch("gateway_found", 32'(want.found[FOUND_GATEWAY]),
							32'(gateway_found));
					if (dns_found !== want.found[FOUND_DNS])
						report_mismatch("dns_found", 32'(want.found[FOUND_DNS]),
							32'(dns_found));
				end
			end
			if (in_valid && in_ready)
				predict_request(data_byte, field_start, field_last);
			outstanding <= result_q.size();
		end
	end

endmodule

[dv/dhcp_option_extract_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the DHCP option extractor: request stimulus, output back-pressure and verdict.
module dhcp_option_extract_tb;
	import dhcpx_pkg::*;

	localparam int          REQUEST_TARGET = 600;
	localparam int          CYCLE_LIMIT    = 300000;
	localparam int          HOLD_CYCLES    = 250;
	localparam logic [31:0] COOKIE         = {8'd99, 8'd130, 8'd83, 8'd99};

	typedef struct packed {
		logic       opens;
		logic       closes;
		logic [7:0] b;
	} octet_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic [7:0]  data_byte   = '0;
	logic        field_start = 1'b0;
	logic        field_last  = 1'b0;
	logic        out_ready   = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [1:0]  status;
	logic [31:0] subnet_mask;
	logic [31:0] gateway_addr;
	logic [31:0] dns_addr;
	logic        mask_found;
	logic        gateway_found;
	logic        dns_found;
	int          fail_count;
	int          outstanding;

	octet_t field_q[$];
	int     src_idle_max  = 0;
	int     sink_idle_max = 0;
	bit     hold_req      = 1'b0;
	int     requests_sent = 0;

	always #1 clk = ~clk;

	dhcp_option_extract u_dut (.*);

	dhcp_option_extract_checker u_checker (.*);

	task automatic send_request(input octet_t o);
		int gap;
		gap = $urandom_range(0, src_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= o.b;
		field_start <= o.opens;
		field_last  <= o.closes;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_field(input int counted);
		foreach (field_q[i])
			send_request(field_q[i]);
		requests_sent += counted;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic void push_byte(input logic [7:0] b);
		field_q.push_back({2'b00, b});
	endfunction

	function automatic void push_cookie(input int bad_lane);
		logic [7:0] c;
		for (int i = 0; i < 4; i++) begin
			c = COOKIE[31 - 8 * i -: 8];
			if (i == bad_lane)
				c = c ^ 8'($urandom_range(1, 255));
			push_byte(c);
		end
	endfunction

	function automatic void push_option(input logic [7:0] code, input int len);
		push_byte(code);
		push_byte(8'(len));
		repeat (len) push_byte(8'($urandom));
	endfunction

	function automatic int pick_len();
		if ($urandom_range(0, 2) != 0)
			return 4;
		return $urandom_range(0, 7);
	endfunction

	task automatic run_options_field();
		int bad_lane;
		int end_at;
		int close_at;
		int pick;
		int useful;
		bad_lane = -1;
		field_q.delete();
		if ($urandom_range(0, 19) == 0)
			bad_lane = $urandom_range(0, 3);
		push_cookie(bad_lane);
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 7))
				0, 1: push_byte(OPT_PAD);
				2: push_option(OPT_MASK, pick_len());
				3: push_option(OPT_GATEWAY, pick_len());
				4: push_option(OPT_DNS, pick_len());
				5: push_option(OPT_DNS, pick_len());
				default: begin
					if ($urandom_range(0, 59) == 0)
						push_option(8'($urandom_range(1, 254)), $urandom_range(100, 255));
					else
						push_option(8'($urandom_range(1, 254)), pick_len());
				end
			endcase
		end
		if ($urandom_range(0, 6) != 0)
			push_byte(OPT_END);
		end_at = field_q.size() - 1;
		repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
		pick = $urandom_range(0, 19);
		if (pick < 13)
			close_at = end_at;
		else if (pick < 16)
			close_at = field_q.size() - 1;
		else if (pick < 19)
			close_at = $urandom_range(0, end_at);
		else
			close_at = -1;
		if (close_at >= 0)
			field_q[close_at].closes = 1'b1;
		field_q[0].opens = ($urandom_range(0, 19) != 0);
		useful = (close_at >= 0 && close_at < end_at) ? close_at + 1 : end_at + 1;
		send_field(useful);
	endtask

	task automatic run_noise_field();
		int len;
		octet_t o;
		len = $urandom_range(1, 8);
		field_q.delete();
		repeat (len) begin
			o.b      = 8'($urandom);
			o.opens  = ($urandom_range(0, 3) == 0);
			o.closes = ($urandom_range(0, 2) == 0);
			field_q.push_back(o);
		end
		send_field(len);
	endtask

	task automatic run_directed();
		int n;
		src_idle_max  = 3;
		sink_idle_max = 3;

		// First field after reset has no start marker and walks every record kind.
		field_q.delete();
		push_cookie(-1);
		push_byte(OPT_MASK);
		push_byte(8'd4);
		repeat (4) push_byte(8'hFF);
		push_byte(OPT_PAD);
		push_byte(OPT_GATEWAY);
		push_byte(8'd2);
		push_byte(8'h00);
		push_byte(8'h80);
		push_byte(OPT_DNS);
		push_byte(8'd0);
		push_byte(OPT_END);
		field_q[field_q.size() - 1].closes = 1'b1;
		send_field(field_q.size());

		// Bad cookie on the closing byte itself.
		field_q.delete();
		push_cookie(3);
		field_q[0].opens  = 1'b1;
		field_q[3].closes = 1'b1;
		send_field(4);

		// Bad cookie early, then an ignored end code carrying the last marker.
		field_q.delete();
		push_cookie(0);
		push_byte(OPT_END);
		field_q[0].opens  = 1'b1;
		field_q[4].closes = 1'b1;
		send_field(4);

		// Long value, then a field cut off just after a length byte.
		field_q.delete();
		push_cookie(-1);
		push_byte(OPT_DNS);
		push_byte(8'd6);
		for (int i = 1; i <= 6; i++)
			push_byte(8'(i));
		push_byte(OPT_MASK);
		push_byte(8'd1);
		n = field_q.size();
		field_q[0].opens      = 1'b1;
		field_q[n - 1].closes = 1'b1;
		send_field(n);

		// Single byte field, cut off inside the cookie.
		field_q.delete();
		push_byte(8'd99);
		field_q[0].opens  = 1'b1;
		field_q[0].closes = 1'b1;
		send_field(1);
	endtask

	initial begin : sink
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			gap = $urandom_range(0, sink_idle_max);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin : source
		int field_n;
		field_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain();

		// Results back up behind a long output stall while one-byte fields keep arriving.
		hold_req      = 1'b1;
		src_idle_max  = 0;
		sink_idle_max = 0;
		field_q.delete();
		push_byte(8'($urandom));
		field_q[0].opens  = 1'b1;
		field_q[0].closes = 1'b1;
		repeat (30) send_field(1);
		drain();

		while (requests_sent < REQUEST_TARGET) begin
			if (field_n % 15 == 0) begin
				case ($urandom_range(0, 3))
					0: begin
						src_idle_max  = 0;
						sink_idle_max = 0;
					end
					1: begin
						src_idle_max  = 18;
						sink_idle_max = 0;
					end
					2: begin
						src_idle_max  = 0;
						sink_idle_max = 18;
					end
					default: begin
						src_idle_max  = 18;
						sink_idle_max = 18;
					end
				endcase
			end
			if ($urandom_range(0, 4) == 0)
				run_noise_field();
			else
				run_options_field();
			if ($urandom_range(0, 24) == 0)
				drain();
			field_n++;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/dhcpx_pkg.sv
rtl/dhcpx_parser.sv
rtl/dhcpx_out_reg.sv
rtl/dhcp_option_extract.sv
dv/dhcp_option_extract_checker.sv
dv/dhcp_option_extract_tb.sv
